// ----- hw/rtl/rhw_pkg.sv -----
// ----------------------------------------------------------------------------
// rhw_pkg
// Shared constants and types of the receive history window: window size,
// window mask and the record of newest sequence number plus window bitmap.
// ----------------------------------------------------------------------------
package rhw_pkg;

  localparam int unsigned SEQ_W       = 32;
  localparam int unsigned HALF_W      = 64;
  localparam int unsigned WIN_STORE_W = 2 * HALF_W;
  localparam int unsigned SHIFT_W     = $clog2(WIN_STORE_W);

  // Active window size, from 8 up to WIN_STORE_W bits.
  localparam int unsigned WINDOW_BITS = 128;

  localparam logic [WIN_STORE_W-1:0] WIN_MASK =
    (WINDOW_BITS >= WIN_STORE_W) ? {WIN_STORE_W{1'b1}} :
    ((WIN_STORE_W'(1) << WINDOW_BITS) - WIN_STORE_W'(1));

  localparam logic [SEQ_W-1:0] WIN_LIMIT = SEQ_W'(WINDOW_BITS);

  typedef struct packed {
    logic [SEQ_W-1:0]       newest;
    logic [WIN_STORE_W-1:0] window;
  } rhw_state_t;

endpackage

// ----- hw/rtl/rhw_update.sv -----
// ----------------------------------------------------------------------------
// rhw_update
// Next-state logic: given the stored newest number and window and one
// received sequence number, start a fresh window, slide or mark the window.
// ----------------------------------------------------------------------------
module rhw_update (
  input  rhw_pkg::rhw_state_t       cur,
  input  logic [rhw_pkg::SEQ_W-1:0] seq,
  output rhw_pkg::rhw_state_t       nxt
);

  logic [rhw_pkg::SEQ_W-1:0]       ahead;
  logic [rhw_pkg::SEQ_W-1:0]       behind;
  logic [rhw_pkg::WIN_STORE_W-1:0] slid;
  logic [rhw_pkg::WIN_STORE_W-1:0] marked;

  assign ahead  = seq - cur.newest;
  assign behind = cur.newest - seq;

  always_comb begin
    if (ahead >= rhw_pkg::WIN_LIMIT) begin
      slid = '0;
    end else begin
      slid = (cur.window << ahead[rhw_pkg::SHIFT_W-1:0]) & rhw_pkg::WIN_MASK;
    end
    marked = cur.window;
    if (behind < rhw_pkg::WIN_LIMIT) begin
      marked[behind[rhw_pkg::SHIFT_W-1:0]] = 1'b1;
    end
  end

  always_comb begin
    nxt = cur;
    priority if (cur.newest == '0) begin
      nxt.newest = seq;
      nxt.window = rhw_pkg::WIN_STORE_W'(1);
    end else if (seq > cur.newest) begin
      nxt.newest = seq;
      nxt.window = slid | rhw_pkg::WIN_STORE_W'(1);
    end else if (seq < cur.newest) begin
      nxt.window = marked & rhw_pkg::WIN_MASK;
    end
  end

endmodule

// ----- hw/rtl/receive_history_window_core.sv -----
// ----------------------------------------------------------------------------
// receive_history_window_core
// Tracks received frame sequence numbers in a sliding receipt bitmap and
// reports newest number plus window after every frame.
// ----------------------------------------------------------------------------
// One frame number enters per cycle; each transfer yields one report
// through the input register, then the result register that also holds
// the updated history. The window slide is a combinational barrel shift
// between these registers, so throughput is one frame per clock as long as
// the report side takes results. Reset clears the history: the first frame
// seen starts a fresh window, and a stored newest number of zero counts as
// no history.
module receive_history_window_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [rhw_pkg::SEQ_W-1:0]         in_seq_number,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [rhw_pkg::SEQ_W-1:0]         out_newest_seq,
  output logic [rhw_pkg::HALF_W-1:0]        out_window_low,
  output logic [rhw_pkg::HALF_W-1:0]        out_window_high
);

  logic                      s1_valid_r;
  logic                      s1_valid_nxt;
  logic [rhw_pkg::SEQ_W-1:0] s1_seq_r;
  logic                      s1_advance;
  logic                      out_valid_r;
  logic                      out_valid_nxt;
  rhw_pkg::rhw_state_t       hist_r;
  rhw_pkg::rhw_state_t       hist_nxt;

  rhw_update u_update (
    .cur (hist_r),
    .seq (s1_seq_r),
    .nxt (hist_nxt)
  );

  assign s1_advance = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready   = !s1_valid_r || s1_advance;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_valid && in_ready) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_advance) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      hist_r      <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_advance) begin
        hist_r <= hist_nxt;
      end
    end
  end

  // hold the captured frame number until it moves on
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_seq_r <= in_seq_number;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_newest_seq  = hist_r.newest;
  assign out_window_low  = hist_r.window[rhw_pkg::HALF_W-1:0];
  assign out_window_high = hist_r.window[rhw_pkg::WIN_STORE_W-1:rhw_pkg::HALF_W];

endmodule

// ----- hw/rtl/rhw_checker.sv -----
// ----------------------------------------------------------------------------
// rhw_checker
// Port-level checks on the receive history window reports.
// ----------------------------------------------------------------------------
module rhw_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [rhw_pkg::SEQ_W-1:0]  out_newest_seq,
  input logic [rhw_pkg::HALF_W-1:0] out_window_low,
  input logic [rhw_pkg::HALF_W-1:0] out_window_high
);

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("report valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_newest_seq) &&
      $stable(out_window_low) && $stable(out_window_high))
    else $error("stalled report changed");

  a_newest_marked: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_window_low[0])
    else $error("newest frame not marked in window");

  a_zero_history: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_newest_seq == '0 |->
      out_window_low == rhw_pkg::HALF_W'(1) && out_window_high == '0)
    else $error("zero newest with window other than one");

endmodule

bind receive_history_window_core rhw_checker u_rhw_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_newest_seq  (out_newest_seq),
  .out_window_low  (out_window_low),
  .out_window_high (out_window_high)
);
